/* rtl/sclpd_pkg.sv */
// Package for the soft-clip low-pass distortion block: sizes, codes, state type and tanh table.
package sclpd_pkg;

  localparam int CHANNELS     = 2;
  localparam int TANH_ENTRIES = 1024;

  localparam int SAMPLE_W = 16;
  localparam int DRIVE_W  = 10;
  localparam int ALPHA_W  = 16;
  localparam int LEVEL_W  = 10;
  localparam int GAIN_W   = 14;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  localparam int RANGE_SHIFT = 27;
  localparam int IDX_W       = $clog2(TANH_ENTRIES + 1);
  localparam int SLOT_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TANH_W      = 15;

  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic signed [PROD_W-1:0] HALF_CLIP  = PROD_W'(1) << (RANGE_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] HALF_FILT  = PROD_W'(1) << 15;
  localparam logic signed [PROD_W-1:0] HALF_LEVEL = PROD_W'(1) << 9;

  localparam logic [DRIVE_W-1:0] DRIVE_RESET = 10'd512;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd24530;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 10'd512;

  localparam logic [1:0] REG_DRIVE = 2'd0;
  localparam logic [1:0] REG_ALPHA = 2'd1;
  localparam logic [1:0] REG_LEVEL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_RANGE,
    ST_ADDR,
    ST_READ_A,
    ST_READ_B,
    ST_INTERP,
    ST_CLIP,
    ST_FILTER,
    ST_STORE,
    ST_LEVEL,
    ST_ROUND,
    ST_DONE
  } sclpd_state_t;

  typedef logic [TANH_W-1:0] tanh_rom_t [0:TANH_ENTRIES];

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], num[k]};
      if (r >= den) begin
        r    = r - den;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(32767 * tanh(4*i/TANH_ENTRIES)) via exp(-2u) series
  function automatic logic [TANH_W-1:0] tanh_point(input int unsigned i);
    logic [63:0]        v16;
    logic [63:0]        w;
    logic [63:0]        term;
    logic [63:0]        t;
    logic [63:0]        num;
    logic [63:0]        den;
    logic signed [63:0] sum;
    v16  = (64'(i) << 19) / TANH_ENTRIES;
    w    = v16 << 11;
    sum  = $signed(Q30_ONE);
    term = Q30_ONE;
    for (int n = 1; n <= 14; n++) begin
      term = udiv64((term * w) >> 30, 64'(n));
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed(Q30_ONE)) begin
      sum = $signed(Q30_ONE);
    end
    t = sum;
    for (int k = 0; k < 3; k++) begin
      t = (t * t + (64'd1 << 29)) >> 30;
    end
    num = (Q30_ONE - t) * 64'd32767;
    den = Q30_ONE + t;
    return TANH_W'(udiv64(num + (den >> 1), den));
  endfunction

  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t rom;
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      rom[i] = tanh_point(i);
    end
    return rom;
  endfunction

endpackage

/* rtl/sclpd_sample_if.sv */
// Input channel: one sample item with its channel number.
interface sclpd_sample_if import sclpd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       channel_index;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source(output valid, output channel_index, output sample_in, input ready);
  modport sink(input valid, input channel_index, input sample_in, output ready);
endinterface

/* rtl/sclpd_result_if.sv */
// Output channel: one processed sample item with its channel number.
interface sclpd_result_if import sclpd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       channel_out;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source(output valid, output channel_out, output sample_out, input ready);
  modport sink(input valid, input channel_out, input sample_out, output ready);
endinterface

/* rtl/soft_clip_lowpass_distortion_top.sv */
// Soft-clip distortion with per-channel one-pole low-pass and output level.
// Each sample item is gained by 1 + 10*drive/1024, soft-clipped through an interpolated
// tanh ROM (full scale beyond 4.0), low-pass filtered with the state of its channel,
// then scaled by the output level with saturation. One result item per input item.
// Items are processed one at a time by a sequencer around a single shared 28x18
// multiplier and the tanh ROM. The steps are five multiplies and two registered ROM
// reads; the ROM reads and the interpolation are skipped when the gained sample lies
// beyond the table range. A finished result waits in the output register while the
// next item is accepted. Registers: drive at 0x0, alpha at 0x4, level at 0x8; write
// only while the block is idle.
module soft_clip_lowpass_distortion_top import sclpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sclpd_sample_if.sink       samples,
  sclpd_result_if.source     results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  sclpd_state_t state, state_next;

  logic [DRIVE_W-1:0] drive_amount;
  logic [ALPHA_W-1:0] lowpass_alpha;
  logic [LEVEL_W-1:0] output_level;

  logic                       ch_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       neg_q;
  logic [IDX_W-1:0]           idx_q;
  logic [RANGE_SHIFT-1:0]     frac_q;
  logic [TANH_W-1:0]          a_q;
  logic signed [SAMPLE_W-1:0] clip_q;
  logic signed [SAMPLE_W-1:0] filt_q;
  logic signed [SAMPLE_W-1:0] lvl_q;

  logic                       out_valid;
  logic                       out_ch;
  logic signed [SAMPLE_W-1:0] out_sample;

  logic signed [SAMPLE_W-1:0] fmem [CHANNELS];

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [IDX_W-1:0]  rom_addr;
  logic [TANH_W-1:0] rom_q;

  logic                       accept;
  logic                       cfg_write;
  logic [GAIN_W-1:0]          gain;
  logic [SLOT_W-1:0]          slot;
  logic signed [SAMPLE_W-1:0] last;
  logic [PROD_W-1:0]          mag;
  logic                       over;
  logic [TANH_W-1:0]          b_max;
  logic [TANH_W-1:0]          delta;
  logic signed [PROD_W-1:0]   clip_sh;
  logic [SAMPLE_W-1:0]        y_mag;
  logic signed [SAMPLE_W-1:0] clip_val;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   filt_sh;
  logic signed [SAMPLE_W+2:0] filt_sum;
  logic signed [SAMPLE_W-1:0] filt_val;
  logic signed [PROD_W-1:0]   lvl_sh;
  logic signed [SAMPLE_W-1:0] lvl_val;
  logic                       load_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_amount  <= DRIVE_RESET;
      lowpass_alpha <= ALPHA_RESET;
      output_level  <= LEVEL_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_DRIVE: drive_amount  <= pwdata[DRIVE_W-1:0];
        REG_ALPHA: lowpass_alpha <= pwdata[ALPHA_W-1:0];
        REG_LEVEL: output_level  <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DRIVE: prdata = DATA_W'(drive_amount);
      REG_ALPHA: prdata = DATA_W'(lowpass_alpha);
      REG_LEVEL: prdata = DATA_W'(output_level);
      default:   prdata = '0;
    endcase
  end

  assign accept        = samples.valid && samples.ready;
  assign samples.ready = (state == ST_IDLE);

  assign results.valid       = out_valid;
  assign results.channel_out = out_ch;
  assign results.sample_out  = out_sample;

  // gain = 1024 + 10*drive
  assign gain = GAIN_W'(1024) + GAIN_W'({drive_amount, 3'b000}) + GAIN_W'({drive_amount, 1'b0});

  assign slot = (CHANNELS > 1) ? SLOT_W'(ch_q) : '0;
  assign last = fmem[slot];

  assign mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign over = |mag[PROD_W-1:RANGE_SHIFT];

  assign b_max = (rom_q < a_q) ? a_q : rom_q;
  assign delta = b_max - a_q;

  assign clip_sh  = (prod + HALF_CLIP) >>> RANGE_SHIFT;
  assign y_mag    = SAMPLE_W'(a_q) + clip_sh[SAMPLE_W-1:0];
  assign clip_val = neg_q ? -$signed(y_mag) : $signed(y_mag);

  assign diff = {clip_q[SAMPLE_W-1], clip_q} - {last[SAMPLE_W-1], last};

  assign filt_sh  = (prod + HALF_FILT) >>> 16;
  assign filt_sum = {{3{last[SAMPLE_W-1]}}, last}
                  + {filt_sh[SAMPLE_W+1], filt_sh[SAMPLE_W+1:0]};
  always_comb begin
    if (filt_sum > $signed((SAMPLE_W+3)'(32767))) begin
      filt_val = 16'sh7fff;
    end else if (filt_sum < -$signed((SAMPLE_W+3)'(32768))) begin
      filt_val = 16'sh8000;
    end else begin
      filt_val = filt_sum[SAMPLE_W-1:0];
    end
  end

  assign lvl_sh = (prod + HALF_LEVEL) >>> 10;
  always_comb begin
    if (lvl_sh > $signed(PROD_W'(32767))) begin
      lvl_val = 16'sh7fff;
    end else if (lvl_sh < -$signed(PROD_W'(32768))) begin
      lvl_val = 16'sh8000;
    end else begin
      lvl_val = lvl_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    rom_addr   = idx_q;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN: begin
        mul_a      = {{(MUL_A_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
        mul_b      = $signed(MUL_B_W'(gain));
        state_next = ST_RANGE;
      end
      ST_RANGE: begin
        mul_a      = $signed(MUL_A_W'(mag[RANGE_SHIFT-1:0]));
        mul_b      = $signed(MUL_B_W'(TANH_ENTRIES));
        state_next = over ? ST_FILTER : ST_ADDR;
      end
      ST_ADDR: begin
        rom_addr   = prod[RANGE_SHIFT +: IDX_W];
        state_next = ST_READ_A;
      end
      ST_READ_A: begin
        rom_addr   = idx_q + IDX_W'(1);
        state_next = ST_READ_B;
      end
      ST_READ_B: begin
        // hold the upper point for the interpolation step
        rom_addr   = idx_q + IDX_W'(1);
        state_next = ST_INTERP;
      end
      ST_INTERP: begin
        mul_a      = $signed(MUL_A_W'(frac_q));
        mul_b      = $signed(MUL_B_W'(delta));
        state_next = ST_CLIP;
      end
      ST_CLIP: begin
        state_next = ST_FILTER;
      end
      ST_FILTER: begin
        mul_a      = {{(MUL_A_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff};
        mul_b      = $signed(MUL_B_W'(lowpass_alpha));
        state_next = ST_STORE;
      end
      ST_STORE: begin
        state_next = ST_LEVEL;
      end
      ST_LEVEL: begin
        mul_a      = {{(MUL_A_W-SAMPLE_W){filt_q[SAMPLE_W-1]}}, filt_q};
        mul_b      = $signed(MUL_B_W'(output_level));
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    rom_q <= TANH_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ch_q <= samples.channel_index;
          x_q  <= samples.sample_in;
        end
      end
      ST_RANGE: begin
        neg_q  <= prod[PROD_W-1];
        clip_q <= prod[PROD_W-1] ? -16'sd32767 : 16'sd32767;
      end
      ST_ADDR: begin
        idx_q  <= prod[RANGE_SHIFT +: IDX_W];
        frac_q <= prod[RANGE_SHIFT-1:0];
      end
      ST_READ_A: a_q    <= rom_q;
      ST_CLIP:   clip_q <= clip_val;
      ST_STORE:  filt_q <= filt_val;
      ST_ROUND:  lvl_q  <= lvl_val;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fmem[c] <= '0;
      end
    end else if (state == ST_STORE) begin
      fmem[slot] <= filt_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch     <= ch_q;
      out_sample <= lvl_q;
    end
  end

endmodule
